@@ hw/rtl/id3p_pkg.sv @@
// Shared types and constants of the ID3v2.2 tag and frame parser.
package id3p_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_FRAMEHDR,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_HDR_OK  = 2'd1;
  localparam logic [1:0] EV_FRAME   = 2'd2;
  localparam logic [1:0] EV_HDR_BAD = 2'd3;

  localparam logic [3:0] STOP_NONE   = 4'd0;
  localparam logic [3:0] BAD_MAGIC   = 4'd1;
  localparam logic [3:0] BAD_VERSION = 4'd2;
  localparam logic [3:0] NO_ROOM     = 4'd3;
  localparam logic [3:0] PADDING     = 4'd4;
  localparam logic [3:0] ZERO_SIZE   = 4'd5;
  localparam logic [3:0] OVERSIZE    = 4'd6;
  localparam logic [3:0] TAG_DONE    = 4'd7;

  localparam logic [4:0] CODE_PIC     = 5'd15;
  localparam logic [4:0] CODE_UNKNOWN = 5'd16;

  localparam int unsigned NUM_KEYS = 15;

  // Known frame keys in code order.
  localparam logic [23:0] KEY_TABLE [NUM_KEYS] = '{
    24'h54414C, 24'h545432, 24'h54434D, 24'h544352, 24'h544441,
    24'h544C45, 24'h545045, 24'h54524B, 24'h545945, 24'h54434F,
    24'h434F4D, 24'h545353, 24'h545858, 24'h525641, 24'h545031
  };
  localparam logic [23:0] KEY_PIC = 24'h504943;

  localparam logic [7:0] MAGIC_0 = 8'h49;
  localparam logic [7:0] MAGIC_1 = 8'h44;
  localparam logic [7:0] MAGIC_2 = 8'h33;
  localparam logic [7:0] VERSION = 8'h02;

  localparam logic [3:0]  HDR_LAST      = 4'd9;
  localparam logic [3:0]  FHDR_LAST     = 4'd5;
  localparam logic [27:0] FRAME_HDR_LEN = 28'd6;

endpackage

@@ hw/rtl/id3p_ifs.sv @@
// Stream channels of the ID3v2.2 parser: raw file bytes in, parse events out.
interface id3p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface id3p_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [4:0]  frame_code;
  logic [27:0] size_value;
  logic [7:0]  payload_byte;
  logic        last_of_frame;
  logic [3:0]  stop_reason;

  modport source (output valid, event_kind, frame_code, size_value, payload_byte,
                  last_of_frame, stop_reason, input ready);
  modport sink   (input valid, event_kind, frame_code, size_value, payload_byte,
                  last_of_frame, stop_reason, output ready);
endinterface

@@ hw/rtl/id3p_key_class.sv @@
// Frame key classifier: maps a 3-byte key to its frame code.
module id3p_key_class
  import id3p_pkg::*;
(
  input  logic [23:0] key,
  output logic [4:0]  code
);

  logic [NUM_KEYS-1:0] hit;

  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      hit[i] = (key == KEY_TABLE[i]);
    end
  end

  // Table keys are distinct, so at most one hit.
  always_comb begin
    code = (key == KEY_PIC) ? CODE_PIC : CODE_UNKNOWN;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (hit[i]) code = 5'(i);
    end
  end

endmodule

@@ hw/rtl/id3v22_tag_frame_parser.sv @@
// Top level of the ID3v2.2 tag and frame parser.
// Takes one file byte per beat and gives at most one event per byte: header
// accepted or rejected on the tenth header byte, frame started on the sixth
// frame header byte, and one event per payload byte. A beat is taken every
// cycle while the output is not stalled; a byte passes an input register and
// leaves from the result register. The tag size comes from the 28-bit syncsafe
// field, and frames are checked against the tag bytes left. After a stop,
// bytes are dropped until one arrives with first_byte set.
module id3v22_tag_frame_parser
  import id3p_pkg::*;
(
  input logic         clk,
  input logic         rst,
  id3p_in_if.sink     byte_in,
  id3p_out_if.source  event_out
);

  // Input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_first;

  // Parse state
  phase_t      phase;
  logic [3:0]  byte_index;
  logic [1:0]  header_bad;
  logic [27:0] tag_left;
  logic [23:0] key_bytes;
  logic [23:0] fsize_acc;
  logic [23:0] payload_left;
  logic [4:0]  current_code;

  // State seen by the byte in the input register (restart applied)
  phase_t      cur_phase;
  logic [3:0]  cur_index;
  logic [1:0]  cur_bad;
  logic [27:0] cur_tag;
  logic [23:0] cur_key;
  logic [23:0] cur_size;
  logic [23:0] cur_pl;
  logic [4:0]  cur_code;

  phase_t      phase_next;
  logic [3:0]  byte_index_next;
  logic [1:0]  header_bad_next;
  logic [27:0] tag_left_next;
  logic [23:0] key_bytes_next;
  logic [23:0] fsize_acc_next;
  logic [23:0] payload_left_next;
  logic [4:0]  current_code_next;

  // Result register
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [4:0]  res_code;
  logic [27:0] res_size;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [3:0]  res_stop;

  logic [1:0]  res_kind_next;
  logic [4:0]  res_code_next;
  logic [27:0] res_size_next;
  logic [7:0]  res_byte_next;
  logic        res_last_next;
  logic [3:0]  res_stop_next;
  logic        produce;

  logic        proc;
  logic [7:0]  magic_exp;
  logic [4:0]  class_code;
  logic [27:0] room;
  logic [27:0] size_wide;

  function automatic logic [3:0] frame_check(input logic [27:0] left);
    if (left == 28'd0) begin
      return TAG_DONE;
    end else if (left < FRAME_HDR_LEN) begin
      return NO_ROOM;
    end else begin
      return STOP_NONE;
    end
  endfunction

  assign proc          = in_full && (!res_valid || event_out.ready);
  assign byte_in.ready = !in_full || proc;

  always_comb begin
    cur_phase = in_first ? PH_HEADER    : phase;
    cur_index = in_first ? 4'd0         : byte_index;
    cur_bad   = in_first ? 2'd0         : header_bad;
    cur_tag   = in_first ? 28'd0        : tag_left;
    cur_key   = in_first ? 24'd0        : key_bytes;
    cur_size  = in_first ? 24'd0        : fsize_acc;
    cur_pl    = in_first ? 24'd0        : payload_left;
    cur_code  = in_first ? CODE_UNKNOWN : current_code;
  end

  always_comb begin
    unique case (cur_index[1:0])
      2'd0:    magic_exp = MAGIC_0;
      2'd1:    magic_exp = MAGIC_1;
      default: magic_exp = MAGIC_2;
    endcase
  end

  id3p_key_class u_key_class (
    .key  (cur_key),
    .code (class_code)
  );

  assign room = cur_tag - FRAME_HDR_LEN;

  always_comb begin
    phase_next        = cur_phase;
    byte_index_next   = cur_index;
    header_bad_next   = cur_bad;
    tag_left_next     = cur_tag;
    key_bytes_next    = cur_key;
    fsize_acc_next    = cur_size;
    payload_left_next = cur_pl;
    current_code_next = cur_code;
    produce           = 1'b0;
    res_kind_next     = EV_PAYLOAD;
    res_code_next     = CODE_UNKNOWN;
    res_size_next     = 28'd0;
    res_byte_next     = 8'd0;
    res_last_next     = 1'b0;
    res_stop_next     = STOP_NONE;
    size_wide         = {4'd0, cur_size};

    unique case (cur_phase)
      PH_HEADER: begin
        if (cur_index < 4'd3) begin
          if (in_byte != magic_exp && cur_bad == 2'd0) begin
            header_bad_next = BAD_MAGIC[1:0];
          end
        end else if (cur_index == 4'd3) begin
          if (in_byte != VERSION && cur_bad == 2'd0) begin
            header_bad_next = BAD_VERSION[1:0];
          end
        end else if (cur_index >= 4'd6) begin
          tag_left_next = {cur_tag[20:0], in_byte[6:0]};
        end
        if (cur_index < HDR_LAST) begin
          byte_index_next = cur_index + 4'd1;
        end else begin
          byte_index_next = 4'd0;
          produce         = 1'b1;
          if (header_bad_next != 2'd0) begin
            phase_next    = PH_STOPPED;
            res_kind_next = EV_HDR_BAD;
            res_stop_next = {2'd0, header_bad_next};
          end else begin
            res_kind_next = EV_HDR_OK;
            res_size_next = tag_left_next;
            res_stop_next = frame_check(tag_left_next);
            phase_next    = (res_stop_next != STOP_NONE) ? PH_STOPPED : PH_FRAMEHDR;
          end
        end
      end

      PH_FRAMEHDR: begin
        if (cur_index < 4'd3) begin
          key_bytes_next = {cur_key[15:0], in_byte};
        end else begin
          fsize_acc_next = {cur_size[15:0], in_byte};
        end
        size_wide = {4'd0, fsize_acc_next};
        if (cur_index < FHDR_LAST) begin
          byte_index_next = cur_index + 4'd1;
        end else begin
          // Key is complete on the last frame header byte.
          byte_index_next   = 4'd0;
          produce           = 1'b1;
          current_code_next = class_code;
          res_kind_next     = EV_FRAME;
          res_code_next     = class_code;
          res_size_next     = size_wide;
          priority if (cur_key[23:16] == 8'd0) begin
            res_stop_next = PADDING;
          end else if (fsize_acc_next == 24'd0) begin
            res_stop_next = ZERO_SIZE;
          end else if (size_wide > room) begin
            res_stop_next = OVERSIZE;
          end else begin
            res_stop_next = STOP_NONE;
          end
          if (res_stop_next != STOP_NONE) begin
            phase_next = PH_STOPPED;
          end else begin
            tag_left_next     = room - size_wide;
            payload_left_next = fsize_acc_next;
            phase_next        = PH_PAYLOAD;
          end
        end
      end

      PH_PAYLOAD: begin
        produce       = 1'b1;
        res_kind_next = EV_PAYLOAD;
        res_code_next = cur_code;
        res_byte_next = in_byte;
        if (cur_pl > 24'd1) begin
          payload_left_next = cur_pl - 24'd1;
        end else begin
          payload_left_next = 24'd0;
          res_last_next     = 1'b1;
          res_stop_next     = frame_check(cur_tag);
          phase_next        = (res_stop_next != STOP_NONE) ? PH_STOPPED : PH_FRAMEHDR;
        end
      end

      PH_STOPPED: begin
        produce = 1'b0;
      end

      default: begin
        produce = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte  <= byte_in.data_byte;
      in_first <= byte_in.first_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_index   <= 4'd0;
      header_bad   <= 2'd0;
      tag_left     <= 28'd0;
      key_bytes    <= 24'd0;
      fsize_acc    <= 24'd0;
      payload_left <= 24'd0;
      current_code <= CODE_UNKNOWN;
    end else if (proc) begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      header_bad   <= header_bad_next;
      tag_left     <= tag_left_next;
      key_bytes    <= key_bytes_next;
      fsize_acc    <= fsize_acc_next;
      payload_left <= payload_left_next;
      current_code <= current_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc) begin
      res_valid <= produce;
    end else if (event_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Hold the result until the beat is taken.
  always_ff @(posedge clk) begin
    if (proc && produce) begin
      res_kind <= res_kind_next;
      res_code <= res_code_next;
      res_size <= res_size_next;
      res_byte <= res_byte_next;
      res_last <= res_last_next;
      res_stop <= res_stop_next;
    end
  end

  assign event_out.valid         = res_valid;
  assign event_out.event_kind    = res_kind;
  assign event_out.frame_code    = res_code;
  assign event_out.size_value    = res_size;
  assign event_out.payload_byte  = res_byte;
  assign event_out.last_of_frame = res_last;
  assign event_out.stop_reason   = res_stop;

endmodule
